// ----- src/binary_gcd_top_assert.svh -----
// ----------------------------------------------------------------------------
// binary gcd assertion macros
// shared property forms for the binary gcd block, clocked on i_clk
// ----------------------------------------------------------------------------
`ifndef BINARY_GCD_TOP_ASSERT_SVH
`define BINARY_GCD_TOP_ASSERT_SVH

// same-cycle implication
`define BGCD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define BGCD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ----- src/bgcd_pkg.sv -----
// ----------------------------------------------------------------------------
// bgcd_pkg
// shared widths, datapath command codes and control structs
// ----------------------------------------------------------------------------
package bgcd_pkg;

    localparam int FIELD_WIDTH       = 64;
    localparam int DIVISOR_WIDTH     = 63;
    localparam int OPERAND_WIDTH_DEF = 64;

    typedef logic [3:0] t_dp_op;

    localparam t_dp_op DP_HOLD    = 4'd0;
    localparam t_dp_op DP_LOAD    = 4'd1;
    localparam t_dp_op DP_NEG_A   = 4'd2;
    localparam t_dp_op DP_NEG_B   = 4'd3;
    localparam t_dp_op DP_HALF_AB = 4'd4;
    localparam t_dp_op DP_HALF_A  = 4'd5;
    localparam t_dp_op DP_HALF_B  = 4'd6;
    localparam t_dp_op DP_SUB     = 4'd7;
    localparam t_dp_op DP_SWAP    = 4'd8;
    localparam t_dp_op DP_DBL_A   = 4'd9;
    localparam t_dp_op DP_B_TO_A  = 4'd10;

    typedef logic [1:0] t_unit_sel;

    localparam t_unit_sel SEL_NEG_A = 2'd0;
    localparam t_unit_sel SEL_NEG_B = 2'd1;
    localparam t_unit_sel SEL_SUB   = 2'd2;

    typedef struct packed {
        t_dp_op    op;
        t_unit_sel sel;
    } t_dp_cmd;

    typedef struct packed {
        logic a_sign;
        logic b_sign;
        logic any_min;
        logic a_zero;
        logic b_zero;
        logic a_lsb;
        logic b_lsb;
        logic borrow;
    } t_dp_stat;

endpackage

// ----- src/bgcd_if.sv -----
// ----------------------------------------------------------------------------
// bgcd channel interfaces
// valid/ready channels for operand words and result words
// ----------------------------------------------------------------------------
interface bgcd_in_if;
    import bgcd_pkg::*;

    logic                          valid;
    logic                          ready;
    logic signed [FIELD_WIDTH-1:0] first_value;
    logic signed [FIELD_WIDTH-1:0] second_value;

    modport source (output valid, output first_value, output second_value, input ready);
    modport sink   (input valid, input first_value, input second_value, output ready);
endinterface

interface bgcd_out_if;
    import bgcd_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [DIVISOR_WIDTH-1:0] divisor;
    logic                     invalid;

    modport source (output valid, output divisor, output invalid, input ready);
    modport sink   (input valid, input divisor, input invalid, output ready);
endinterface

// ----- src/bgcd_dp.sv -----
// ----------------------------------------------------------------------------
// bgcd_dp
// working registers and the shared subtract/shift unit
// ----------------------------------------------------------------------------
module bgcd_dp #(
    parameter int OPERAND_WIDTH = bgcd_pkg::OPERAND_WIDTH_DEF
) (
    input  logic                     i_clk,
    input  bgcd_pkg::t_dp_cmd        i_cmd,
    input  logic [OPERAND_WIDTH-1:0] i_first,
    input  logic [OPERAND_WIDTH-1:0] i_second,
    output bgcd_pkg::t_dp_stat       o_stat,
    output logic [OPERAND_WIDTH-1:0] o_result
);
    import bgcd_pkg::*;

    localparam logic [OPERAND_WIDTH-1:0] MIN_VAL = {1'b1, {(OPERAND_WIDTH-1){1'b0}}};

    logic [OPERAND_WIDTH-1:0] r_a, n_a;
    logic [OPERAND_WIDTH-1:0] r_b, n_b;
    logic [OPERAND_WIDTH-1:0] w_x, w_y;
    logic [OPERAND_WIDTH:0]   w_diff;

    // shared subtractor: 0 - a, 0 - b or b - a
    assign w_x    = (i_cmd.sel == SEL_SUB) ? r_b : '0;
    assign w_y    = (i_cmd.sel == SEL_NEG_B) ? r_b : r_a;
    assign w_diff = {1'b0, w_x} - {1'b0, w_y};

    always_comb begin
        n_a = r_a;
        n_b = r_b;
        case (i_cmd.op)
            DP_LOAD: begin
                n_a = i_first;
                n_b = i_second;
            end
            DP_NEG_A:   n_a = w_diff[OPERAND_WIDTH-1:0];
            DP_NEG_B:   n_b = w_diff[OPERAND_WIDTH-1:0];
            DP_HALF_AB: begin
                n_a = r_a >> 1;
                n_b = r_b >> 1;
            end
            DP_HALF_A:  n_a = r_a >> 1;
            DP_HALF_B:  n_b = r_b >> 1;
            DP_SUB:     n_b = w_diff[OPERAND_WIDTH-1:0];
            DP_SWAP: begin
                n_a = r_b;
                n_b = r_a;
            end
            DP_DBL_A:   n_a = r_a << 1;
            DP_B_TO_A:  n_a = r_b;
            default: begin
                n_a = r_a;
                n_b = r_b;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_a <= n_a;
        r_b <= n_b;
    end

    always_comb begin
        o_stat.a_sign  = r_a[OPERAND_WIDTH-1];
        o_stat.b_sign  = r_b[OPERAND_WIDTH-1];
        o_stat.any_min = (r_a == MIN_VAL) || (r_b == MIN_VAL);
        o_stat.a_zero  = (r_a == '0);
        o_stat.b_zero  = (r_b == '0);
        o_stat.a_lsb   = r_a[0];
        o_stat.b_lsb   = r_b[0];
        o_stat.borrow  = w_diff[OPERAND_WIDTH];
    end

    assign o_result = r_a;

endmodule

// ----- src/bgcd_ctrl.sv -----
// ----------------------------------------------------------------------------
// bgcd_ctrl
// sequencer stepping the shared unit through stein's method
// ----------------------------------------------------------------------------
module bgcd_ctrl #(
    parameter int OPERAND_WIDTH = bgcd_pkg::OPERAND_WIDTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic               i_out_free,
    input  bgcd_pkg::t_dp_stat i_stat,
    output bgcd_pkg::t_dp_cmd  o_cmd,
    output logic               o_done,
    output logic               o_invalid
);
    import bgcd_pkg::*;

    localparam int CW = $clog2(OPERAND_WIDTH);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_NEGA = 4'd1;
    localparam logic [3:0] S_NEGB = 4'd2;
    localparam logic [3:0] S_ZERO = 4'd3;
    localparam logic [3:0] S_TWOS = 4'd4;
    localparam logic [3:0] S_ODDA = 4'd5;
    localparam logic [3:0] S_RED  = 4'd6;
    localparam logic [3:0] S_SHL  = 4'd7;
    localparam logic [3:0] S_DONE = 4'd8;

    logic [3:0]    r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic          r_inv, n_inv;

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_inv      = r_inv;
        o_cmd.op   = DP_HOLD;
        o_cmd.sel  = SEL_SUB;
        o_in_ready = 1'b0;
        o_done     = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.op = DP_LOAD;
                    n_count  = '0;
                    n_inv    = 1'b0;
                    n_state  = S_NEGA;
                end
            end
            S_NEGA: begin
                o_cmd.sel = SEL_NEG_A;
                if (i_stat.any_min) begin
                    n_inv   = 1'b1;
                    n_state = S_DONE;
                end else begin
                    if (i_stat.a_sign) begin
                        o_cmd.op = DP_NEG_A;
                    end
                    n_state = S_NEGB;
                end
            end
            S_NEGB: begin
                o_cmd.sel = SEL_NEG_B;
                if (i_stat.b_sign) begin
                    o_cmd.op = DP_NEG_B;
                end
                n_state = S_ZERO;
            end
            S_ZERO: begin
                if (i_stat.a_zero) begin
                    o_cmd.op = DP_B_TO_A;
                    n_state  = S_DONE;
                end else if (i_stat.b_zero) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_TWOS;
                end
            end
            S_TWOS: begin
                if (!i_stat.a_lsb && !i_stat.b_lsb) begin
                    o_cmd.op = DP_HALF_AB;
                    n_count  = r_count + CW'(1);
                end else begin
                    n_state = S_ODDA;
                end
            end
            S_ODDA: begin
                if (!i_stat.a_lsb) begin
                    o_cmd.op = DP_HALF_A;
                end else begin
                    n_state = S_RED;
                end
            end
            S_RED: begin
                if (i_stat.b_zero) begin
                    n_state = S_SHL;
                end else if (!i_stat.b_lsb) begin
                    o_cmd.op = DP_HALF_B;
                end else if (i_stat.borrow) begin
                    o_cmd.op = DP_SWAP;
                end else begin
                    o_cmd.op = DP_SUB;
                end
            end
            S_SHL: begin
                if (r_count == '0) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.op = DP_DBL_A;
                    n_count  = r_count - CW'(1);
                end
            end
            S_DONE: begin
                if (i_out_free) begin
                    o_done  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_inv   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_inv   <= n_inv;
        end
    end

    assign o_invalid = r_inv;

endmodule

// ----- src/binary_gcd_top.sv -----
// sequence: a most-negative operand goes from the sign check straight to the result word,
//   a zero operand from the zero check; otherwise the time is set by the halving,
//   swap and subtract steps through the one shared subtractor
// input: no new word while busy
// reset: synchronous active-low, clears sequencer and output valid only
// ----------------------------------------------------------------------------
// binary_gcd_top
// greatest common divisor of two signed operands by stein's binary method
// ----------------------------------------------------------------------------
module binary_gcd_top #(
    parameter int OPERAND_WIDTH = bgcd_pkg::OPERAND_WIDTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    bgcd_in_if.sink    i_in,
    bgcd_out_if.source o_out
);
    import bgcd_pkg::*;

    `include "binary_gcd_top_assert.svh"

    t_dp_cmd                  w_cmd;
    t_dp_stat                 w_stat;
    logic [OPERAND_WIDTH-1:0] w_result;
    logic [FIELD_WIDTH-1:0]   w_result_ext;
    logic                     w_in_ready;
    logic                     w_done;
    logic                     w_invalid;
    logic                     w_out_free;

    logic                     r_out_valid;
    logic [DIVISOR_WIDTH-1:0] r_out_divisor;
    logic                     r_out_invalid;

    assign w_out_free = !r_out_valid || o_out.ready;

    bgcd_ctrl #(
        .OPERAND_WIDTH(OPERAND_WIDTH)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (w_in_ready),
        .i_out_free (w_out_free),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd),
        .o_done     (w_done),
        .o_invalid  (w_invalid)
    );

    bgcd_dp #(
        .OPERAND_WIDTH(OPERAND_WIDTH)
    ) u_dp (
        .i_clk    (i_clk),
        .i_cmd    (w_cmd),
        .i_first  (i_in.first_value[OPERAND_WIDTH-1:0]),
        .i_second (i_in.second_value[OPERAND_WIDTH-1:0]),
        .o_stat   (w_stat),
        .o_result (w_result)
    );

    assign w_result_ext = FIELD_WIDTH'(w_result);

    // output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_done) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_done) begin
            r_out_divisor <= w_invalid ? '0 : w_result_ext[DIVISOR_WIDTH-1:0];
            r_out_invalid <= w_invalid;
        end
    end

    assign i_in.ready    = w_in_ready;
    assign o_out.valid   = r_out_valid;
    assign o_out.divisor = r_out_divisor;
    assign o_out.invalid = r_out_invalid;

    `BGCD_ASSERT_NOW(a_inv_zero, r_out_valid && r_out_invalid, r_out_divisor == '0, "invalid word with nonzero divisor")
    `BGCD_ASSERT_NEXT(a_busy_after_accept, i_in.valid && w_in_ready, !w_in_ready && !w_done, "not busy after accept")
    `BGCD_ASSERT_NOW(a_done_free, w_done, w_out_free, "result overwrote a waiting word")
    `BGCD_ASSERT_NOW(a_idle_no_done, w_in_ready, !w_done, "result raised while idle")

endmodule

// ----- test/binary_gcd_top_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// binary_gcd_top testbench
// drives signed operand pairs through the input channel and checks every
// result word against the corner table's expected word or a bit-accurate
// stein gcd predictor kept in the bench; a short table of corner pairs runs
// first, then about fourteen hundred random pairs, with bursty input pacing,
// patterned result stalls, one long result hold-off and full drains between phases
// ----------------------------------------------------------------------------
module binary_gcd_top_test;
    import bgcd_pkg::*;

    localparam int          CYCLE_LIMIT  = 2_500_000;
    localparam int          RANDOM_WORDS = 1428;
    localparam int          MID_DRAIN_AT = 700;
    localparam int          HOLD_AFTER   = 300;
    localparam int          LONG_HOLD    = 600;
    localparam int          SETTLE       = 4 * OPERAND_WIDTH_DEF + 40;
    localparam logic [63:0] MOST_NEG     = 64'h8000_0000_0000_0000;
    localparam logic [63:0] MOST_POS     = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [DIVISOR_WIDTH-1:0] DIV_MAX = '1;

    typedef struct packed {
        logic [DIVISOR_WIDTH-1:0] divisor;
        logic                     invalid;
    } t_gcd_word;

    typedef struct packed {
        logic [63:0] first;
        logic [63:0] second;
        logic        typed;
        t_gcd_word   want;
    } t_operand_row;

    typedef enum logic [1:0] {
        PACE_OPEN,
        PACE_COIN,
        PACE_CYCLIC,
        PACE_SPARSE
    } t_pace;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    bgcd_in_if  in_ch ();
    bgcd_out_if out_ch ();

    binary_gcd_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    t_operand_row offered_q[$];
    t_gcd_word    gcd_due_q[$];
    t_operand_row corner_rows[$];

    int error_count    = 0;
    int words_in       = 0;
    int words_out      = 0;
    int invalid_seen   = 0;
    int drains         = 0;
    int cycle_count    = 0;
    int burst_left     = 0;
    bit long_hold_done = 1'b0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic t_gcd_word stein_gcd(input logic [63:0] x, input logic [63:0] y);
        logic [63:0] u;
        logic [63:0] v;
        logic [63:0] t;
        int          shift;
        t_gcd_word   w;
        w = '0;
        if (x == MOST_NEG || y == MOST_NEG) begin
            w.invalid = 1'b1;
            return w;
        end
        u = x[63] ? -x : x;
        v = y[63] ? -y : y;
        shift = 0;
        if (u == 64'd0) begin
            t = v;
        end else if (v == 64'd0) begin
            t = u;
        end else begin
            while (!(u[0] | v[0])) begin
                u = u >> 1;
                v = v >> 1;
                shift++;
            end
            while (!u[0]) u = u >> 1;
            while (v != 64'd0) begin
                while (!v[0]) v = v >> 1;
                if (u > v) begin
                    t = u;
                    u = v;
                    v = t;
                end
                v = v - u;
            end
            t = u << shift;
        end
        w.divisor = t[DIVISOR_WIDTH-1:0];
        return w;
    endfunction

    task automatic add_row(input logic [63:0] a, input logic [63:0] b, input logic typed,
                           input logic [DIVISOR_WIDTH-1:0] div, input logic inv);
        t_operand_row row;
        row.first        = a;
        row.second       = b;
        row.typed        = typed;
        row.want.divisor = div;
        row.want.invalid = inv;
        corner_rows.push_back(row);
    endtask

    task automatic pick_operands(output logic [63:0] a, output logic [63:0] b);
        logic [63:0] g;
        logic [63:0] k1;
        logic [63:0] k2;
        logic [63:0] t;
        int unsigned kind;
        int unsigned sh;
        kind = $urandom_range(0, 99);
        if (kind < 30) begin
            a = {$urandom, $urandom};
            b = {$urandom, $urandom};
        end else if (kind < 55) begin
            g  = {$urandom, $urandom} >> $urandom_range(33, 62);
            k1 = {32'd0, $urandom} >> $urandom_range(0, 31);
            k2 = {32'd0, $urandom} >> $urandom_range(0, 31);
            a  = g * k1;
            b  = g * k2;
        end else if (kind < 70) begin
            sh = $urandom_range(0, 62);
            a  = {$urandom, $urandom} << sh;
            b  = {$urandom, $urandom} << (sh + $urandom_range(0, 1));
        end else if (kind < 80) begin
            a = {32'd0, $urandom_range(0, 200)} - 64'd100;
            b = {32'd0, $urandom_range(0, 200)} - 64'd100;
        end else if (kind < 88) begin
            a = {$urandom, $urandom} >> $urandom_range(0, 40);
            case ($urandom_range(0, 2))
                0:       b = 64'd0;
                1:       b = a;
                default: b = a * $urandom_range(1, 1000);
            endcase
        end else if (kind < 93) begin
            a = MOST_NEG;
            b = $urandom_range(0, 3) == 0 ? MOST_NEG : {$urandom, $urandom};
        end else begin
            a = MOST_POS - $urandom_range(0, 1000);
            b = MOST_NEG + $urandom_range(0, 1000);
        end
        if ($urandom_range(0, 1)) a = -a;
        if ($urandom_range(0, 1)) b = -b;
        if ($urandom_range(0, 1)) begin
            t = a;
            a = b;
            b = t;
        end
    endtask

    task automatic offer_operands(input t_operand_row row);
        int unsigned gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0) begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? 60 : $urandom_range(1, 12);
        end
        burst_left--;
        offered_q.push_back(row);
        in_ch.valid        <= 1'b1;
        in_ch.first_value  <= row.first;
        in_ch.second_value <= row.second;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
    endtask

    task automatic drain_results();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (offered_q.size() != 0 || gcd_due_q.size() != 0) @(posedge i_clk);
        drains++;
        burst_left = 0;
    endtask

    // operand words in, expected words queued, result words checked
    always @(posedge i_clk) begin : watch
        t_operand_row row;
        t_gcd_word    want;
        t_gcd_word    got;
        if (i_rst_n) begin
            if (in_ch.valid && in_ch.ready && offered_q.size() != 0) begin
                row = offered_q.pop_front();
                gcd_due_q.push_back(row.typed ? row.want : stein_gcd(row.first, row.second));
                words_in++;
            end
            if (out_ch.valid && out_ch.ready) begin
                got.divisor = out_ch.divisor;
                got.invalid = out_ch.invalid;
                words_out++;
                if (got.invalid) invalid_seen++;
                if (gcd_due_q.size() == 0) begin
                    $error("result word with nothing expected: divisor %h invalid %b",
                           got.divisor, got.invalid);
                    error_count++;
                end else begin
                    want = gcd_due_q.pop_front();
                    if (got.divisor !== want.divisor) begin
                        $error("divisor mismatch: expected %h, actual %h",
                               want.divisor, got.divisor);
                        error_count++;
                    end
                    if (got.invalid !== want.invalid) begin
                        $error("invalid mismatch: expected %b, actual %b",
                               want.invalid, got.invalid);
                        error_count++;
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d words still due",
                     cycle_count, gcd_due_q.size() + offered_q.size());
            $display("** binary_gcd_top: FAILED **");
            $finish;
        end
    end

    // result channel pacing
    initial begin : result_pacing
        t_pace pace;
        int    span;
        int    k;
        logic  rdy;
        out_ch.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (!long_hold_done && words_in >= HOLD_AFTER) begin
                long_hold_done = 1'b1;
                out_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end
            pace = t_pace'($urandom_range(0, 3));
            span = $urandom_range(50, 400);
            for (k = 0; k < span; k++) begin
                case (pace)
                    PACE_OPEN:   rdy = 1'b1;
                    PACE_COIN:   rdy = 1'($urandom_range(0, 1));
                    PACE_CYCLIC: rdy = (k % 7) >= 3;
                    default:     rdy = ($urandom_range(0, 9) != 0);
                endcase
                out_ch.ready <= rdy;
                @(posedge i_clk);
            end
        end
    end

    initial begin : operand_source
        t_operand_row row;
        logic [63:0]  a;
        logic [63:0]  b;
        int           i;
        in_ch.valid        <= 1'b0;
        in_ch.first_value  <= '0;
        in_ch.second_value <= '0;

        // zero operands, most negative value, extremes, then mixed pairs
        add_row(64'd0, 64'd0, 1'b1, '0, 1'b0);
        add_row(64'd0, 64'd5, 1'b1, 63'd5, 1'b0);
        add_row(-64'd7, 64'd0, 1'b1, 63'd7, 1'b0);
        add_row(MOST_NEG, 64'd3, 1'b1, '0, 1'b1);
        add_row(64'd4, MOST_NEG, 1'b1, '0, 1'b1);
        add_row(MOST_NEG, MOST_NEG, 1'b1, '0, 1'b1);
        add_row(MOST_NEG, 64'd0, 1'b1, '0, 1'b1);
        add_row(64'd0, MOST_NEG, 1'b1, '0, 1'b1);
        add_row(MOST_POS, MOST_POS, 1'b1, DIV_MAX, 1'b0);
        add_row(MOST_POS, 64'd0, 1'b1, DIV_MAX, 1'b0);
        add_row(MOST_NEG + 64'd1, MOST_POS, 1'b1, DIV_MAX, 1'b0);
        add_row(64'd0, MOST_NEG + 64'd1, 1'b1, DIV_MAX, 1'b0);
        add_row(64'd1, 64'd1, 1'b0, '0, 1'b0);
        add_row(-64'd1, -64'd1, 1'b0, '0, 1'b0);
        add_row(64'h4000_0000_0000_0000, 64'h2000_0000_0000_0000, 1'b0, '0, 1'b0);
        add_row(64'd48, -64'd18, 1'b0, '0, 1'b0);
        add_row(MOST_POS, 64'd1, 1'b0, '0, 1'b0);
        add_row(64'hC000_0000_0000_0000, 64'h4000_0000_0000_0000, 1'b0, '0, 1'b0);
        add_row(MOST_POS, MOST_POS - 64'd1, 1'b0, '0, 1'b0);
        add_row(-64'd1, MOST_NEG + 64'd1, 1'b0, '0, 1'b0);
        add_row(64'd12345678910, -64'd98765432110, 1'b0, '0, 1'b0);
        add_row(64'h5555_5555_5555_5555, 64'h2AAA_AAAA_AAAA_AAAA, 1'b0, '0, 1'b0);
        add_row(-64'd1_000_000_007 * 64'd6, 64'd1_000_000_007 * 64'd10, 1'b0, '0, 1'b0);

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (corner_rows[n]) offer_operands(corner_rows[n]);
        drain_results();

        for (i = 0; i < RANDOM_WORDS; i++) begin
            if (i == MID_DRAIN_AT) drain_results();
            pick_operands(a, b);
            row.first  = a;
            row.second = b;
            row.typed  = 1'b0;
            row.want   = '0;
            offer_operands(row);
        end
        drain_results();
        repeat (SETTLE) @(posedge i_clk);

        $display("covered %0d operand words (%0d from the corner table) and %0d result words,",
                 words_in, corner_rows.size(), words_out);
        $display("%0d flagged invalid, %0d full drains, one result hold-off of %0d cycles",
                 invalid_seen, drains, LONG_HOLD);
        if (error_count == 0) begin
            $display("** binary_gcd_top: PASSED **");
        end else begin
            $display("** binary_gcd_top: FAILED **");
        end
        $finish;
    end

endmodule
